FILE: src/rcts_pkg.sv
// shared types, constants and fixed-point helpers for the rc thermal step core
package rcts_pkg;

    localparam int CORES   = 4;
    localparam int CIDX_W  = (CORES > 1) ? $clog2(CORES) : 1;

    // configuration register indexes
    localparam logic [2:0] REG_CORE_RES      = 3'd0;
    localparam logic [2:0] REG_CORE_CAP_RES  = 3'd1;
    localparam logic [2:0] REG_BASE_RES      = 3'd2;
    localparam logic [2:0] REG_BASE_CAP_RES  = 3'd3;
    localparam logic [2:0] REG_SETTLE_THRESH = 3'd4;

    localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SMIN = 32'sh8000_0000;

    // request to the shared divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [33:0] den;
    } div_req_t;

    // saturate a 34 bit signed sum to int32
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF)       r = SMAX;
        else if (v < -34'sh0_8000_0000) r = SMIN;
        else                            r = v[31:0];
        return r;
    endfunction

    // saturate a wide signed value to int32
    function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sh00_7FFF_FFFF)       r = SMAX;
        else if (v < -40'sh00_8000_0000) r = SMIN;
        else                             r = v[31:0];
        return r;
    endfunction

endpackage

FILE: src/rc_thermal_network_step_core.sv
// top level of the rc thermal network step core
//
// Usage: configuration writes arrive on cfg_valid/cfg_ready with cfg_index
// and cfg_data; each write to a resistance starts a recompute of the gain and
// reciprocals through the shared divider (seven divisions), during which no
// beat is taken on either channel. A threshold write starts no recompute.
// A config beat offered with an input beat goes first.
// Input: one core_power beat per core, in core order. Each beat runs one
// multiply through the shared multiplier, and the next beat is not taken
// until that product is stored. After the last core's beat the step runs a
// sequencer over the same multiplier to the first result, then CORES result
// beats leave from the output register, one per cycle while out_ready is
// high.
// While results wait (out_ready low) the block holds and takes no input.
// Reset clears history, stored rises and the arrival count, loads the reset
// register values and runs the derive pass before the first beat is taken.
module rc_thermal_network_step_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [31:0]                   core_power,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    core_number,
    output logic signed [31:0]            core_rise,
    output logic signed [31:0]            base_rise,
    output logic                          settled,
    output logic                          last_core
);
    import rcts_pkg::*;

    typedef enum logic [8:0] {
        ST_DERIVE = 9'b000000001,
        ST_DWAIT  = 9'b000000010,
        ST_IDLE   = 9'b000000100,
        ST_PT     = 9'b000001000,
        ST_VB     = 9'b000010000,
        ST_CORE   = 9'b000100000,
        ST_EB     = 9'b001000000,
        ST_EB2    = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t state_reg;

    logic [23:0] rc_reg, rcap_reg, rb_reg, rbcap_reg;
    logic [31:0] thr_reg;
    logic signed [31:0] gain_reg, inv_r_reg, inv_rc_reg, inv_rcap_reg, inv_rb_reg,
                        inv_rbcap_reg, rpar_reg;
    logic signed [31:0] pc_reg [CORES];
    logic signed [31:0] eh_reg [CORES];
    logic signed [31:0] vcs_reg [CORES];
    logic signed [31:0] ebh_reg, vb_reg, vc_reg, d_reg, t_reg;
    logic signed [39:0] acc_reg;
    logic signed [39:0] vbacc_reg;
    logic [32:0] eps_reg;
    logic [CIDX_W-1:0] k_reg, ci_reg;
    logic [2:0] dsel_reg;
    logic [3:0] ph_reg;
    logic [CIDX_W-1:0] oi_reg;
    logic [32:0] core_power_hold;
    logic [31:0] cp_reg;

    // shared units
    div_req_t dreq;
    logic dbusy;
    logic [63:0] dq;
    logic signed [31:0] ma, mb, mp;

    rcts_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy), .quot(dq));
    rcts_qmul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

    logic [24:0] rcr, rcapr, rbr, rbcapr, rsum;
    assign rcr    = (rc_reg == 0) ? 25'd1 : {1'b0, rc_reg};
    assign rcapr  = (rcap_reg == 0) ? 25'd1 : {1'b0, rcap_reg};
    assign rbr    = (rb_reg == 0) ? 25'd1 : {1'b0, rb_reg};
    assign rbcapr = (rbcap_reg == 0) ? 25'd1 : {1'b0, rbcap_reg};
    assign rsum   = rcr + rcapr;

    logic signed [31:0] qsat;
    assign qsat = (dq > 64'h7FFF_FFFF) ? SMAX : dq[31:0];

    logic [33:0] gsum;
    assign gsum = 34'(CORES) * {2'b0, inv_r_reg} + {2'b0, inv_rb_reg}
                + {2'b0, inv_rbcap_reg};

    assign core_power_hold = {1'b0, cp_reg};

    // divider request per derive slot
    always_comb
    begin
        dreq.start = (state_reg == ST_DERIVE);
        dreq.num   = 64'h1_0000_0000;
        dreq.den   = {9'd0, rsum};
        case (dsel_reg)
            3'd0: begin dreq.num = {23'd0, rcapr, 16'd0}; dreq.den = {9'd0, rsum}; end
            3'd1: dreq.den = {9'd0, rsum};
            3'd2: dreq.den = {9'd0, rcr};
            3'd3: dreq.den = {9'd0, rcapr};
            3'd4: dreq.den = {9'd0, rbr};
            3'd5: dreq.den = {9'd0, rbcapr};
            3'd6: dreq.den = (gsum == 0) ? 34'd1 : gsum;
            default: dreq.den = 34'd1;
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        ma = vb_reg;
        mb = inv_r_reg;
        case (state_reg)
            ST_PT:
            begin
                ma = sat34(34'(signed'(core_power_hold)) + 34'(eh_reg[k_reg]));
                mb = gain_reg;
            end
            ST_VB:
            begin
                ma = sat40(vbacc_reg);
                mb = rpar_reg;
            end
            ST_CORE:
            begin
                case (ph_reg)
                    4'd0: begin ma = vb_reg; mb = inv_r_reg; end
                    4'd2: begin ma = d_reg; mb = $signed({8'd0, rcr[23:0]}); end
                    4'd4: begin ma = sat34(34'(vc_reg) - 34'(vb_reg)); mb = inv_rc_reg; end
                    default: begin ma = vc_reg; mb = inv_rcap_reg; end
                endcase
            end
            ST_EB:  begin ma = vb_reg; mb = inv_rbcap_reg; end
            ST_EB2: begin ma = vb_reg; mb = inv_rb_reg; end
            default: ;
        endcase
    end

    logic signed [32:0] diff;
    logic [32:0] adiff;
    logic signed [31:0] vc_new;
    assign vc_new = sat34(34'(vb_reg) + 34'(mp));
    assign diff   = 33'(vcs_reg[ci_reg]) - 33'(vc_reg);
    assign adiff  = diff[32] ? 33'(-diff) : 33'(diff);

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign out_valid = (state_reg == ST_OUT);
    assign core_number = 2'(oi_reg);
    assign core_rise   = vcs_reg[oi_reg];
    assign base_rise   = vb_reg;
    assign settled     = (eps_reg <= {1'b0, thr_reg});
    assign last_core   = (oi_reg == CIDX_W'(CORES - 1));

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DERIVE;
            dsel_reg  <= '0;
            ph_reg    <= '0;
            k_reg     <= '0;
            ci_reg    <= '0;
            oi_reg    <= '0;
            rc_reg    <= 24'd65536;
            rcap_reg  <= 24'd65536;
            rb_reg    <= 24'd65536;
            rbcap_reg <= 24'd65536;
            thr_reg   <= '0;
            ebh_reg   <= '0;
            for (int i = 0; i < CORES; i++)
            begin
                pc_reg[i]  <= '0;
                eh_reg[i]  <= '0;
                vcs_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_DERIVE:
                begin
                    state_reg <= ST_DWAIT;
                end
                ST_DWAIT:
                begin
                    if (!dbusy)
                    begin
                        if (dsel_reg == 3'd6)
                        begin
                            dsel_reg  <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            dsel_reg  <= dsel_reg + 3'd1;
                            state_reg <= ST_DERIVE;
                        end
                    end
                end
                ST_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            REG_CORE_RES:      begin rc_reg <= cfg_data[23:0];
                                                     state_reg <= ST_DERIVE; end
                            REG_CORE_CAP_RES:  begin rcap_reg <= cfg_data[23:0];
                                                     state_reg <= ST_DERIVE; end
                            REG_BASE_RES:      begin rb_reg <= cfg_data[23:0];
                                                     state_reg <= ST_DERIVE; end
                            REG_BASE_CAP_RES:  begin rbcap_reg <= cfg_data[23:0];
                                                     state_reg <= ST_DERIVE; end
                            REG_SETTLE_THRESH: thr_reg <= cfg_data;
                            default: ;
                        endcase
                    end
                    else if (in_valid)
                    begin
                        ph_reg    <= '0;
                        state_reg <= ST_PT;
                    end
                end
                ST_PT:
                begin
                    ph_reg <= ph_reg + 4'd1;
                    if (ph_reg == 4'd1)
                    begin
                        pc_reg[k_reg] <= mp;
                        ph_reg <= '0;
                        if (k_reg == CIDX_W'(CORES - 1))
                        begin
                            k_reg     <= '0;
                            state_reg <= ST_VB;
                        end
                        else
                        begin
                            k_reg     <= k_reg + CIDX_W'(1);
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_VB:
                begin
                    ph_reg <= ph_reg + 4'd1;
                    if (ph_reg == 4'd1)
                    begin
                        vb_reg    <= mp;
                        ph_reg    <= '0;
                        ci_reg    <= '0;
                        acc_reg   <= '0;
                        eps_reg   <= '0;
                        state_reg <= ST_CORE;
                    end
                end
                ST_CORE:
                begin
                    ph_reg <= ph_reg + 4'd1;
                    case (ph_reg)
                        4'd1: d_reg <= sat34(34'(pc_reg[ci_reg]) - 34'(mp));
                        4'd3: vc_reg <= vc_new;
                        4'd4:
                        begin
                            if (adiff > eps_reg) eps_reg <= adiff;
                            vcs_reg[ci_reg] <= vc_reg;
                        end
                        4'd5: acc_reg <= acc_reg + 40'(mp);
                        4'd6:
                        begin
                            eh_reg[ci_reg] <= sat34(34'(mp) * 34'sd2 - 34'(eh_reg[ci_reg]));
                            ph_reg <= '0;
                            if (ci_reg == CIDX_W'(CORES - 1))
                                state_reg <= ST_EB;
                            else
                                ci_reg <= ci_reg + CIDX_W'(1);
                        end
                        default: ;
                    endcase
                end
                ST_EB:
                begin
                    ph_reg <= ph_reg + 4'd1;
                    if (ph_reg == 4'd1)
                    begin
                        t_reg     <= mp;
                        ph_reg    <= '0;
                        state_reg <= ST_EB2;
                    end
                end
                ST_EB2:
                begin
                    ph_reg <= ph_reg + 4'd1;
                    if (ph_reg == 4'd1)
                    begin
                        ebh_reg   <= sat40(acc_reg + 40'(t_reg) - 40'(mp));
                        ph_reg    <= '0;
                        oi_reg    <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        if (last_core)
                            state_reg <= ST_IDLE;
                        else
                            oi_reg <= oi_reg + CIDX_W'(1);
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload: held input beat and derived values
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && !cfg_valid)
            cp_reg <= core_power;
        if (state_reg == ST_DWAIT && !dbusy)
        begin
            case (dsel_reg)
                3'd0: gain_reg      <= dq[31:0];
                3'd1: inv_r_reg     <= qsat;
                3'd2: inv_rc_reg    <= qsat;
                3'd3: inv_rcap_reg  <= qsat;
                3'd4: inv_rb_reg    <= qsat;
                3'd5: inv_rbcap_reg <= qsat;
                3'd6: rpar_reg      <= qsat;
                default: ;
            endcase
        end
    end

    // vb sum over stored points, computed as the last point lands
    logic signed [39:0] psum;
    always_comb
    begin
        psum = 40'(ebh_reg);
        for (int i = 0; i < CORES; i++)
        begin
            if (CIDX_W'(i) == CIDX_W'(CORES - 1))
                psum = psum + 40'(mp);
            else
                psum = psum + 40'(pc_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PT && ph_reg == 4'd1)
            vbacc_reg <= psum;
    end

    // no input while results wait, results held while stalled, no config while the divider is busy
    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while results pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(oi_reg))
        else $error("result dropped while stalled");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !dbusy) else $error("config accepted during derive");
endmodule

FILE: src/rcts_div.sv
// shared restoring divider, one quotient bit per cycle
module rcts_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rcts_pkg::div_req_t   req,
    output logic                 busy,
    output logic [63:0]          quot
);
    import rcts_pkg::*;

    logic [63:0] q_reg;
    logic [34:0] rem_reg;
    logic [33:0] den_reg;
    logic [6:0]  cnt_reg;
    logic [34:0] trial;

    assign trial = {rem_reg[33:0], q_reg[63]} - {1'b0, den_reg};
    assign busy  = (cnt_reg != 7'd0);
    assign quot  = q_reg;

    // one shift-subtract step per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (req.start)
        begin
            cnt_reg <= 7'd64;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy)
        begin
            if (!trial[34])
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[33:0], q_reg[63]};
                q_reg   <= {q_reg[62:0], 1'b0};
            end
        end
    end
endmodule

FILE: src/rcts_qmul.sv
// registered signed q16.16 multiplier, truncating toward zero and saturating
module rcts_qmul (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] p
);
    import rcts_pkg::*;

    logic [31:0] ma, mb;
    logic [63:0] prod;
    logic [47:0] sh;
    logic signed [31:0] p_next;
    logic        neg;

    // magnitude product then sign
    always_comb
    begin
        neg  = a[31] ^ b[31];
        ma   = a[31] ? (~a + 32'd1) : a;
        mb   = b[31] ? (~b + 32'd1) : b;
        prod = ma * mb;
        sh   = prod[63:16];
        if (!neg)
            p_next = (sh > 48'h7FFF_FFFF) ? SMAX : sh[31:0];
        else
            p_next = (sh > 48'h8000_0000) ? SMIN : (~sh[31:0] + 32'd1);
    end

    always_ff @(posedge clk)
    begin
        p <= p_next;
    end
endmodule

FILE: tb/sv/rc_thermal_network_step_core_checker.sv
// checker for the rc thermal step core: watches the channels, predicts results and compares
module rc_thermal_network_step_core_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [31:0]        core_power,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         core_number,
    input  logic signed [31:0] core_rise,
    input  logic signed [31:0] base_rise,
    input  logic               settled,
    input  logic               last_core,
    output int                 fail_count,
    output int                 pending
);
    import rcts_pkg::*;

    typedef struct packed {
        logic [1:0]         number;
        logic signed [31:0] rise;
        logic signed [31:0] base;
        logic               settle;
        logic               last;
    } thermal_result_t;

    thermal_result_t result_q[$];

    logic [23:0] res_core, res_ccap, res_base, res_bcap;
    logic [31:0] thresh;
    logic signed [31:0] point_i[CORES];
    logic signed [31:0] hist_c[CORES];
    logic signed [31:0] rise_c[CORES];
    logic signed [31:0] hist_b;
    int                 arrivals;
    logic signed [31:0] gain, g_r, g_core, g_ccap, g_base, g_bcap, par_r;

    assign pending = result_q.size();

    function automatic logic signed [31:0] clamp(input logic signed [65:0] v);
        if (v > 66'sh7FFF_FFFF) return SMAX;
        if (v < -66'sh8000_0000) return SMIN;
        return v[31:0];
    endfunction

    // signed q16.16 multiply, magnitude truncated
    function automatic logic signed [31:0] fmul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic [63:0]        ma, mb, m;
        logic signed [65:0] v;
        ma = a < 0 ? 64'(-$signed(65'(a))) : 64'(a);
        mb = b < 0 ? 64'(-$signed(65'(b))) : 64'(b);
        m = (ma * mb) >> 16;
        v = $signed({2'b00, m});
        return clamp(((a < 0) != (b < 0)) ? -v : v);
    endfunction

    function automatic logic [63:0] raw_res(input logic [23:0] r);
        return r == 0 ? 64'd1 : 64'(r);
    endfunction

    function automatic logic signed [31:0] inverse(input logic [63:0] r);
        logic [63:0] q;
        q = (64'd1 << 32) / r;
        return q > 64'h7FFF_FFFF ? SMAX : q[31:0];
    endfunction

    // rebuild gain and reciprocals from the registers
    task automatic rederive();
        logic [63:0] rsum, gsum;
        rsum = raw_res(res_core) + raw_res(res_ccap);
        gain = 32'((raw_res(res_ccap) << 16) / rsum);
        g_r = inverse(rsum);
        g_core = inverse(raw_res(res_core));
        g_ccap = inverse(raw_res(res_ccap));
        g_base = inverse(raw_res(res_base));
        g_bcap = inverse(raw_res(res_bcap));
        gsum = 64'(CORES) * 64'(g_r) + 64'(g_base) + 64'(g_bcap);
        par_r = inverse(gsum);
    endtask

    // one power beat; the final core runs the network step
    task automatic take_power(input logic [31:0] p);
        logic signed [65:0] acc;
        logic signed [31:0] vb, d, vc, t;
        logic [63:0]        eps, ad;
        logic signed [65:0] diff;
        thermal_result_t    r;
        int k;
        k = arrivals;
        point_i[k] = fmul(clamp(66'(p) + 66'(hist_c[k])), gain);
        arrivals = k + 1;
        if (arrivals < CORES) return;
        arrivals = 0;
        acc = 66'(hist_b);
        for (int i = 0; i < CORES; i++) acc += 66'(point_i[i]);
        vb = fmul(clamp(acc), par_r);
        acc = 0;
        eps = 0;
        for (int i = 0; i < CORES; i++) begin
            d = clamp(66'(point_i[i]) - 66'(fmul(vb, g_r)));
            vc = clamp(66'(vb) + 66'(fmul(d, $signed(32'(raw_res(res_core))))));
            diff = 66'(rise_c[i]) - 66'(vc);
            ad = diff < 0 ? 64'(-diff) : 64'(diff);
            if (ad > eps) eps = ad;
            rise_c[i] = vc;
            acc += 66'(fmul(clamp(66'(vc) - 66'(vb)), g_core));
            t = fmul(vc, g_ccap);
            hist_c[i] = clamp(2 * 66'(t) - 66'(hist_c[i]));
        end
        acc += 66'(fmul(vb, g_bcap)) - 66'(fmul(vb, g_base));
        hist_b = clamp(acc);
        for (int i = 0; i < CORES; i++) begin
            r.number = 2'(i);
            r.rise = rise_c[i];
            r.base = vb;
            r.settle = eps <= 64'(thresh);
            r.last = (i == CORES - 1);
            result_q = {result_q, r};
        end
    endtask

    // watch the three channels
    always @(posedge clk or negedge rst_n)
    begin
        thermal_result_t want, got;
        if (!rst_n)
        begin
            res_core = 24'h010000;
            res_ccap = 24'h010000;
            res_base = 24'h010000;
            res_bcap = 24'h010000;
            thresh = 0;
            for (int i = 0; i < CORES; i++)
            begin
                point_i[i] = 0;
                hist_c[i] = 0;
                rise_c[i] = 0;
            end
            hist_b = 0;
            arrivals = 0;
            fail_count = 0;
            result_q.delete();
            rederive();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CORE_RES:      res_core = cfg_data[23:0];
                    REG_CORE_CAP_RES:  res_ccap = cfg_data[23:0];
                    REG_BASE_RES:      res_base = cfg_data[23:0];
                    REG_BASE_CAP_RES:  res_bcap = cfg_data[23:0];
                    REG_SETTLE_THRESH: thresh = cfg_data;
                    default: ;
                endcase
                rederive();
            end
            if (in_valid && in_ready) take_power(core_power);
            // compare result beat with oldest expectation
            if (out_valid && out_ready)
            begin
                got = '{core_number, core_rise, base_rise, settled, last_core};
                if (result_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result beat %p", got);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
    end

endmodule

FILE: tb/sv/rc_thermal_network_step_core_test.sv
// testbench top for the rc thermal step core: stimulus, idling phases and verdict
module rc_thermal_network_step_core_test;
    import rcts_pkg::*;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = 0;
    logic [31:0]        cfg_data = 0;
    logic               in_valid = 0;
    logic               in_ready;
    logic [31:0]        core_power = 0;
    logic               out_valid;
    logic               out_ready = 0;
    logic [1:0]         core_number;
    logic signed [31:0] core_rise, base_rise;
    logic               settled, last_core;
    int                 fail_count, pending;
    int                 send_idle = 0, recv_stall = 0;
    int                 quiet_cycles = 0;

    localparam int WATCHDOG = 20000;

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    rc_thermal_network_step_core u_top (.*);

    rc_thermal_network_step_core_checker u_chk (.*);

    // receiver stalls at random
    always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

    // watchdog over cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // valid stays up after a beat until the next task changes it
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        in_valid <= 0;
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic send_power(input logic [31:0] p);
        cfg_valid <= 0;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        core_power <= p;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // wait for all results, then let the step pipeline drain
    task automatic drain();
        in_valid <= 0;
        cfg_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_power();
        case ($urandom_range(5))
            0: return 32'hFFFF_FFFF;
            1: return 0;
            2: return $urandom;
            default: return $urandom_range(32'h0040_0000);
        endcase
    endfunction

    function automatic logic [23:0] rand_res();
        case ($urandom_range(4))
            0: return 24'hFF_FFFF;
            1: return 24'd1;
            default: return 24'(1 + $urandom_range(24'h04_0000));
        endcase
    endfunction

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes at reset settings
        send_power(0); send_power(32'hFFFF_FFFF); send_power(32'h8000_0000);
        send_power(32'h0001_0000);
        send_power(32'hFFFF_FFFF); send_power(32'hFFFF_FFFF);
        send_power(32'hFFFF_FFFF); send_power(32'hFFFF_FFFF);
        drain();
        // zero resistances, out of range index, threshold extreme
        reg_write(REG_CORE_RES, 0);
        reg_write(REG_CORE_CAP_RES, 32'hFF00_0000);
        reg_write(REG_BASE_RES, 0);
        reg_write(REG_BASE_CAP_RES, 32'h00FF_FFFF);
        reg_write(REG_SETTLE_THRESH, 32'hFFFF_FFFF);
        reg_write(3'd7, 32'h1234_5678);
        reg_write(3'd5, 0);
        for (int i = 0; i < 4; i++) send_power(32'h0010_0000 << i);
        // partial frame then write with new gain
        send_power(32'h0002_0000);
        send_power(32'h5555_AAAA);
        in_valid <= 0;
        repeat (50) @(posedge clk);
        reg_write(REG_CORE_CAP_RES, 24'hFF_FFFF);
        reg_write(REG_SETTLE_THRESH, 0);
        send_power(32'hAAAA_5555); send_power(32'h0000_0001);
        drain();

        // random phases with varying settings
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1 || ph == 3) ? (ph == 3 ? 17 : 54) : 0;
            recv_stall = (ph == 2 || ph == 3) ? (ph == 3 ? 17 : 54) : 0;
            reg_write(REG_CORE_RES, rand_res());
            reg_write(REG_CORE_CAP_RES, rand_res());
            reg_write(REG_BASE_RES, rand_res());
            reg_write(REG_BASE_CAP_RES, rand_res());
            reg_write(REG_SETTLE_THRESH, $urandom_range(1) ? $urandom : $urandom_range(32'h1_0000));
            for (int n = 0; n < 24; n++) send_power(rand_power());
            drain();
        end

        send_idle = 0;
        recv_stall = 0;
        drain();
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
src/rcts_pkg.sv
src/rcts_div.sv
src/rcts_qmul.sv
src/rc_thermal_network_step_core.sv
tb/sv/rc_thermal_network_step_core_checker.sv
tb/sv/rc_thermal_network_step_core_test.sv
